>>> hdl/infix_to_postfix_converter_macros.svh
// Assertion macros for the infix-to-postfix converter RTL.
// Included by i2p_back, which carries concurrent checks; no other dependencies.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define I2P_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define I2P_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

>>> hdl/i2p_pkg.sv
// Shared types, token codes and helpers for the infix-to-postfix converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2p_pkg;

    localparam int KIND_W     = 4;
    localparam int VALUE_W    = 16;
    localparam int OP_W       = 3;
    localparam int ARGC_W     = 4;
    localparam int CFG_ADDR_W = 1;

    // input token kinds
    localparam logic [KIND_W-1:0] IN_OPERAND   = 4'd0;
    localparam logic [KIND_W-1:0] IN_USER_FUNC = 4'd1;
    localparam logic [KIND_W-1:0] IN_COMPARE   = 4'd2;
    localparam logic [KIND_W-1:0] IN_STRLEN    = 4'd3;
    localparam logic [KIND_W-1:0] IN_LPAREN    = 4'd4;
    localparam logic [KIND_W-1:0] IN_RPAREN    = 4'd5;
    localparam logic [KIND_W-1:0] IN_COMMA     = 4'd6;
    localparam logic [KIND_W-1:0] IN_PLUS      = 4'd7;
    localparam logic [KIND_W-1:0] IN_MINUS     = 4'd8;
    localparam logic [KIND_W-1:0] IN_STAR      = 4'd9;
    localparam logic [KIND_W-1:0] IN_SLASH     = 4'd10;
    localparam logic [KIND_W-1:0] IN_END       = 4'd11;

    // result kinds
    localparam logic [KIND_W-1:0] OK_OPERAND = 4'd0;
    localparam logic [KIND_W-1:0] OK_CALL    = 4'd6;
    localparam logic [KIND_W-1:0] OK_ARGC    = 4'd7;
    localparam logic [KIND_W-1:0] OK_END     = 4'd8;
    localparam logic [KIND_W-1:0] OK_ERROR   = 4'd9;

    // stack entry codes (same as result kinds 1..5)
    localparam logic [OP_W-1:0] OP_PLUS   = 3'd1;
    localparam logic [OP_W-1:0] OP_MINUS  = 3'd2;
    localparam logic [OP_W-1:0] OP_STAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_SLASH  = 3'd4;
    localparam logic [OP_W-1:0] OP_LPAREN = 3'd5;

    // error codes
    localparam logic [VALUE_W-1:0] ERR_OVERFLOW  = 16'd0;
    localparam logic [VALUE_W-1:0] ERR_UNMATCHED = 16'd1;

    localparam logic [ARGC_W-1:0] ARGC_MAX = 4'd15;
    localparam logic [ARGC_W-1:0] ARGC_ONE = 4'd1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_COMPARE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STRLEN  = 1'd1;

    // commands passed from front to back
    typedef enum logic [2:0] {
        CMD_OPERAND,
        CMD_CALL,
        CMD_LPAREN,
        CMD_RPAREN,
        CMD_COMMA,
        CMD_OPER,
        CMD_END
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [VALUE_W-1:0]  value;
    } cmd_entry_t;

    // operator priority: parens 1, plus/minus 2, star/slash 3
    function automatic logic [1:0] op_prio(input logic [OP_W-1:0] code);
        logic [1:0] p;
        p = 2'd1;
        if (code == OP_PLUS || code == OP_MINUS) begin
            p = 2'd2;
        end else if (code == OP_STAR || code == OP_SLASH) begin
            p = 2'd3;
        end
        return p;
    endfunction

endpackage

>>> hdl/i2p_front.sv
// Front end: accepts tokens, resolves builtin call indexes, writes commands.
// Depends on i2p_pkg; holds the two builtin-index configuration registers.
`timescale 1ns / 1ps

module i2p_front
    import i2p_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [VALUE_W-1:0]    cfg_wdata,
    input  logic                  tok_valid,
    output logic                  tok_ready,
    input  logic [KIND_W-1:0]     tok_kind,
    input  logic [VALUE_W-1:0]    tok_index,
    input  logic                  q_full,
    output logic                  q_wr_en,
    output cmd_entry_t            q_wr_data
);

    logic [VALUE_W-1:0] cmp_idx_reg;
    logic [VALUE_W-1:0] strlen_idx_reg;
    logic               known;
    logic [KIND_W-1:0]  op_diff;

    // builtin index registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_idx_reg    <= '0;
            strlen_idx_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_COMPARE: cmp_idx_reg    <= cfg_wdata;
                REG_STRLEN:  strlen_idx_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // operator code: plus..slash map onto 1..4
    assign op_diff = tok_kind - IN_COMMA;

    // token classification
    always_comb begin
        known           = 1'b1;
        q_wr_data.cmd   = CMD_OPERAND;
        q_wr_data.value = tok_index;
        unique case (tok_kind) inside
            IN_OPERAND:   q_wr_data.cmd = CMD_OPERAND;
            IN_USER_FUNC: q_wr_data.cmd = CMD_CALL;
            IN_COMPARE: begin
                q_wr_data.cmd   = CMD_CALL;
                q_wr_data.value = cmp_idx_reg;
            end
            IN_STRLEN: begin
                q_wr_data.cmd   = CMD_CALL;
                q_wr_data.value = strlen_idx_reg;
            end
            IN_LPAREN:    q_wr_data.cmd = CMD_LPAREN;
            IN_RPAREN:    q_wr_data.cmd = CMD_RPAREN;
            IN_COMMA:     q_wr_data.cmd = CMD_COMMA;
            IN_PLUS, IN_MINUS, IN_STAR, IN_SLASH: begin
                q_wr_data.cmd   = CMD_OPER;
                q_wr_data.value = VALUE_W'(op_diff[OP_W-1:0]);
            end
            IN_END:       q_wr_data.cmd = CMD_END;
            default:      known = 1'b0;   // unknown kinds are dropped
        endcase
    end

    assign tok_ready = !q_full;
    assign q_wr_en   = tok_valid && !q_full && known;

endmodule

>>> hdl/i2p_queue.sv
// Two-entry command queue between front and back.
// Depends on i2p_pkg for the command entry type.
`timescale 1ns / 1ps

module i2p_queue
    import i2p_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  cmd_entry_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output cmd_entry_t rd_data
);

    localparam int QDEPTH = 2;
    localparam int PW     = $clog2(QDEPTH);
    localparam int NW     = $clog2(QDEPTH + 1);

    cmd_entry_t        entries_reg [QDEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [NW-1:0]     fill_reg;
    logic              do_wr;
    logic              do_rd;

    assign full     = fill_reg == NW'(QDEPTH);
    assign rd_valid = fill_reg != '0;
    assign rd_data  = entries_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd) begin
                fill_reg <= fill_reg + NW'(1);
            end else if (do_rd && !do_wr) begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

endmodule

>>> hdl/i2p_back.sv
// Back end: operator stack, call mode and result output register.
// Depends on i2p_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_macros.svh"

module i2p_back
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  cmd_entry_t         q_data,
    output logic               q_rd_en,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_kind,
    output logic [VALUE_W-1:0] m_value,
    output logic               m_last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {S_FETCH, S_RUN, S_ARGC} state_t;

    state_t             state_reg, state_next;
    cmd_entry_t         cmd_reg, cmd_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               in_call_reg, in_call_next;
    logic [VALUE_W-1:0] call_idx_reg, call_idx_next;
    logic [ARGC_W-1:0]  argc_reg, argc_next;
    logic               m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]  m_kind_reg, m_kind_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic               m_last_reg, m_last_next;

    logic [OP_W-1:0]    stack_mem [STACK_DEPTH];
    logic [OP_W-1:0]    top_reg;
    logic [OP_W-1:0]    below_reg;
    logic               push_en;
    logic [OP_W-1:0]    push_code;
    logic [CW-1:0]      top_sum;
    logic [CW-1:0]      below_sum;
    logic [AW-1:0]      top_addr;
    logic [AW-1:0]      below_addr;

    logic               out_free;
    logic               stack_full;
    logic [OP_W-1:0]    op_code;
    logic               pop_top;
    logic               pop_below;

    assign out_free   = !m_valid_reg || m_ready;
    assign stack_full = count_reg == CW'(STACK_DEPTH);
    assign op_code    = cmd_reg.value[OP_W-1:0];

    // operator pops while the incoming one has no higher priority
    assign pop_top   = (count_reg != '0) && (top_reg != OP_LPAREN)
                       && (op_prio(op_code) <= op_prio(top_reg));
    assign pop_below = (count_reg > CW'(1)) && (below_reg != OP_LPAREN)
                       && (op_prio(op_code) <= op_prio(below_reg));

    // sequencer next-state logic
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        in_call_next  = in_call_reg;
        call_idx_next = call_idx_reg;
        argc_next     = argc_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        q_rd_en       = 1'b0;
        push_en       = 1'b0;
        push_code     = OP_LPAREN;

        unique case (state_reg)
            S_FETCH: begin
                if (q_valid) begin
                    q_rd_en    = 1'b1;
                    cmd_next   = q_data;
                    state_next = S_RUN;
                end
            end

            S_RUN: begin
                if (out_free) begin
                    state_next = S_FETCH;
                    if (in_call_reg) begin
                        // call mode: operands, commas and the closing paren only
                        unique case (cmd_reg.cmd)
                            CMD_OPERAND: begin
                                m_valid_next = 1'b1;
                                m_kind_next  = OK_OPERAND;
                                m_value_next = cmd_reg.value;
                                m_last_next  = 1'b1;
                            end
                            CMD_COMMA: begin
                                if (argc_reg != ARGC_MAX) begin
                                    argc_next = argc_reg + ARGC_ONE;
                                end
                            end
                            CMD_RPAREN: begin
                                m_valid_next = 1'b1;
                                m_kind_next  = OK_CALL;
                                m_value_next = call_idx_reg;
                                m_last_next  = 1'b0;
                                state_next   = S_ARGC;
                            end
                            default: ;
                        endcase
                    end else begin
                        unique case (cmd_reg.cmd)
                            CMD_OPERAND: begin
                                m_valid_next = 1'b1;
                                m_kind_next  = OK_OPERAND;
                                m_value_next = cmd_reg.value;
                                m_last_next  = 1'b1;
                            end
                            CMD_CALL: begin
                                in_call_next  = 1'b1;
                                argc_next     = ARGC_ONE;
                                call_idx_next = cmd_reg.value;
                            end
                            CMD_LPAREN: begin
                                if (stack_full) begin
                                    m_valid_next = 1'b1;
                                    m_kind_next  = OK_ERROR;
                                    m_value_next = ERR_OVERFLOW;
                                    m_last_next  = 1'b1;
                                end else begin
                                    push_en    = 1'b1;
                                    push_code  = OP_LPAREN;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            CMD_RPAREN: begin
                                if (count_reg == '0) begin
                                    // no matching open paren left
                                    m_valid_next = 1'b1;
                                    m_kind_next  = OK_ERROR;
                                    m_value_next = ERR_UNMATCHED;
                                    m_last_next  = 1'b1;
                                end else if (top_reg == OP_LPAREN) begin
                                    count_next = count_reg - CW'(1);
                                end else begin
                                    m_valid_next = 1'b1;
                                    m_kind_next  = KIND_W'(top_reg);
                                    m_value_next = '0;
                                    m_last_next  = (count_reg > CW'(1))
                                                   && (below_reg == OP_LPAREN);
                                    count_next   = count_reg - CW'(1);
                                    state_next   = S_RUN;
                                end
                            end
                            CMD_OPER: begin
                                if (pop_top) begin
                                    m_valid_next = 1'b1;
                                    m_kind_next  = KIND_W'(top_reg);
                                    m_value_next = '0;
                                    m_last_next  = !pop_below;
                                    count_next   = count_reg - CW'(1);
                                    state_next   = S_RUN;
                                end else if (stack_full) begin
                                    m_valid_next = 1'b1;
                                    m_kind_next  = OK_ERROR;
                                    m_value_next = ERR_OVERFLOW;
                                    m_last_next  = 1'b1;
                                end else begin
                                    push_en    = 1'b1;
                                    push_code  = op_code;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            CMD_END: begin
                                m_valid_next = 1'b1;
                                m_value_next = '0;
                                if (count_reg != '0) begin
                                    m_kind_next = KIND_W'(top_reg);
                                    m_last_next = 1'b0;
                                    count_next  = count_reg - CW'(1);
                                    state_next  = S_RUN;
                                end else begin
                                    m_kind_next = OK_END;
                                    m_last_next = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            S_ARGC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = OK_ARGC;
                    m_value_next = VALUE_W'(argc_reg);
                    m_last_next  = 1'b1;
                    in_call_next = 1'b0;
                    state_next   = S_FETCH;
                end
            end

            default: state_next = S_FETCH;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_FETCH;
            count_reg    <= '0;
            in_call_reg  <= 1'b0;
            call_idx_reg <= '0;
            argc_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            in_call_reg  <= in_call_next;
            call_idx_reg <= call_idx_next;
            argc_reg     <= argc_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg     <= cmd_next;
        m_kind_reg  <= m_kind_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    // read addresses for the two top entries after this cycle's update
    assign top_sum    = count_next - CW'(1);
    assign below_sum  = count_next - CW'(2);
    assign top_addr   = top_sum[AW-1:0];
    assign below_addr = below_sum[AW-1:0];

    // operator stack memory, one write and two registered reads
    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[count_reg[AW-1:0]] <= push_code;
        end
        if (push_en) begin
            top_reg <= push_code;
        end else if (count_next != '0) begin
            top_reg <= stack_mem[top_addr];
        end
        if (count_next > CW'(1)) begin
            below_reg <= stack_mem[below_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

    `I2P_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > CW'(STACK_DEPTH), "stack count past depth")
    `I2P_ASSERT(a_push_room, aclk, aresetn, push_en |-> !stack_full, "push onto full stack")
    `I2P_ASSERT(a_call_keeps_stack, aclk, aresetn, in_call_reg |=> count_reg == $past(count_reg), "stack moved in call mode")
    `I2P_ASSERT(a_argc_last, aclk, aresetn, m_valid_reg && m_kind_reg == OK_ARGC |-> m_last_reg && m_value_reg != '0, "bad argument count item")

endmodule

>>> hdl/infix_to_postfix_converter.sv
// Infix-to-postfix converter: token stream in, postfix item stream out.
// Depends on i2p_pkg, i2p_front, i2p_queue and i2p_back.
//
// Usage:
//   s_axis carries one classified token per request: tuser = kind,
//   tdata = identifier index. m_axis carries postfix items: tuser = kind,
//   tdata = value, tlast marks the final item caused by one token.
//   Builtin call indexes are set through cfg_we/cfg_addr/cfg_wdata while idle.
// Timing:
//   A token is decoded on acceptance into a two-entry command queue; the
//   back end fetches a command in S_FETCH and executes it in S_RUN, so a
//   token's first item reaches the m_axis register once it executes. Each
//   operator popped off the stack, and the argument count after a call
//   item, adds a further S_RUN or S_ARGC step. The rate is set by the
//   back-end sequencer and its single stack write port.
// Reset and stalls:
//   aresetn (synchronous, active low) empties the stack, leaves call mode
//   and clears both builtin indexes. When m_axis_tready is low the back end
//   holds its item; the queue keeps taking tokens until it is full.
`timescale 1ns / 1ps

module infix_to_postfix_converter
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [VALUE_W-1:0]    cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [VALUE_W-1:0]    s_axis_tdata,   // [15:0] index
    input  logic [KIND_W-1:0]     s_axis_tuser,   // [3:0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [VALUE_W-1:0]    m_axis_tdata,   // [15:0] out_value
    output logic [KIND_W-1:0]     m_axis_tuser,   // [3:0] out_kind
    output logic                  m_axis_tlast
);

    logic       q_wr_en;
    cmd_entry_t q_wr_data;
    logic       q_full;
    logic       q_rd_en;
    logic       q_valid;
    cmd_entry_t q_rd_data;

    i2p_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .tok_valid (s_axis_tvalid),
        .tok_ready (s_axis_tready),
        .tok_kind  (s_axis_tuser),
        .tok_index (s_axis_tdata),
        .q_full    (q_full),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    i2p_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_en    (q_rd_en),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    i2p_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_rd_data),
        .q_rd_en (q_rd_en),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_kind  (m_axis_tuser),
        .m_value (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

endmodule

>>> dv/tb.sv
// Self-checking bench for the infix-to-postfix converter: a token stream in, postfix items out.
// It needs the RTL and i2p_pkg only. A shunting-yard predictor in a scoreboard class gives the
// expected items, and random sender bursts with receiver stalls load both streams.
`timescale 1ns / 1ps

module tb;
    import i2p_pkg::*;

    localparam int STACK_DEPTH   = 32;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 80;
    localparam int NUM_PHASES    = 4;
    // ~420 requests, each up to 33 items, with the receiver starved to a 1-in-16 chance of ready
    // for long stretches: the limit covers the worst case several times over
    localparam int CYCLE_LIMIT   = 1_500_000;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN_LO = IN_END + 4'd1;
    localparam logic [KIND_W-1:0] KIND_TOP        = 4'hF;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] index;
    } token_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } postfix_item_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_BUSY,
        RX_CHOPPY,
        RX_STARVED
    } rx_mode_t;

    // Shunting-yard predictor plus the queue of postfix items still owed by the block
    class postfix_scoreboard;
        logic [OP_W-1:0]    op_stack [64];
        int unsigned        depth;
        bit                 in_call;
        logic [VALUE_W-1:0] call_idx;
        logic [ARGC_W-1:0]  argc;
        logic [VALUE_W-1:0] compare_idx;
        logic [VALUE_W-1:0] strlen_idx;
        postfix_item_t      expected_q [$];
        int                 errors;

        function new();
            depth       = 0;
            in_call     = 1'b0;
            call_idx    = '0;
            argc        = '0;
            compare_idx = '0;
            strlen_idx  = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [VALUE_W-1:0] data);
            if (addr == REG_COMPARE) begin
                compare_idx = data;
            end else if (addr == REG_STRLEN) begin
                strlen_idx = data;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [1:0] stack_rank(logic [OP_W-1:0] code);
            if (code == OP_PLUS || code == OP_MINUS) begin
                return 2'd2;
            end else if (code == OP_STAR || code == OP_SLASH) begin
                return 2'd3;
            end
            return 2'd1;
        endfunction

        function void add_item(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
            postfix_item_t it;
            it.kind  = kind;
            it.value = value;
            it.last  = 1'b0;
            expected_q.push_back(it);
        endfunction

        // full stack: the token is dropped and an overflow error goes out instead
        function void push_op(logic [OP_W-1:0] code);
            if (depth >= STACK_DEPTH) begin
                add_item(OK_ERROR, ERR_OVERFLOW);
            end else begin
                op_stack[depth] = code;
                depth++;
            end
        endfunction

        // Predict one accepted request; returns 0 when the block just ignores it
        function bit note_token(token_t tok);
            int              n_before;
            bit              acted;
            bit              found;
            logic [OP_W-1:0] code;
            n_before = expected_q.size();
            acted    = 1'b1;
            if (in_call) begin
                // call mode: operands pass, commas count, rparen closes the call
                if (tok.kind == IN_OPERAND) begin
                    add_item(OK_OPERAND, tok.index);
                end else if (tok.kind == IN_COMMA) begin
                    if (argc != ARGC_MAX) argc++;
                end else if (tok.kind == IN_RPAREN) begin
                    add_item(OK_CALL, call_idx);
                    add_item(OK_ARGC, VALUE_W'(argc));
                    in_call = 1'b0;
                end else begin
                    acted = 1'b0;
                end
            end else begin
                case (tok.kind)
                    IN_OPERAND: begin
                        add_item(OK_OPERAND, tok.index);
                    end
                    IN_USER_FUNC, IN_COMPARE, IN_STRLEN: begin
                        in_call = 1'b1;
                        argc    = ARGC_ONE;
                        if (tok.kind == IN_USER_FUNC) begin
                            call_idx = tok.index;
                        end else if (tok.kind == IN_COMPARE) begin
                            call_idx = compare_idx;
                        end else begin
                            call_idx = strlen_idx;
                        end
                    end
                    IN_LPAREN: begin
                        push_op(OP_LPAREN);
                    end
                    IN_RPAREN: begin
                        found = 1'b0;
                        while (depth > 0 && !found) begin
                            code = op_stack[depth-1];
                            depth--;
                            if (code == OP_LPAREN) begin
                                found = 1'b1;
                            end else begin
                                add_item(KIND_W'(code), '0);
                            end
                        end
                        if (!found) add_item(OK_ERROR, ERR_UNMATCHED);
                    end
                    IN_PLUS, IN_MINUS, IN_STAR, IN_SLASH: begin
                        case (tok.kind)
                            IN_PLUS:  code = OP_PLUS;
                            IN_MINUS: code = OP_MINUS;
                            IN_STAR:  code = OP_STAR;
                            default:  code = OP_SLASH;
                        endcase
                        while (depth > 0 && op_stack[depth-1] != OP_LPAREN &&
                               stack_rank(code) <= stack_rank(op_stack[depth-1])) begin
                            add_item(KIND_W'(op_stack[depth-1]), '0);
                            depth--;
                        end
                        push_op(code);
                    end
                    IN_END: begin
                        while (depth > 0) begin
                            add_item(KIND_W'(op_stack[depth-1]), '0);
                            depth--;
                        end
                        add_item(OK_END, '0);
                    end
                    default: begin
                        // comma outside a call and unknown kinds
                        acted = 1'b0;
                    end
                endcase
            end
            if (expected_q.size() > n_before) begin
                expected_q[expected_q.size()-1].last = 1'b1;
            end
            return acted;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value, logic last);
            postfix_item_t exp;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item kind=%0d value=%0d last=%0d",
                                          kind, value, last));
            end else begin
                exp = expected_q.pop_front();
                if (kind !== exp.kind)
                    report_mismatch($sformatf("out_kind %0d, expected %0d", kind, exp.kind));
                if (value !== exp.value)
                    report_mismatch($sformatf("out_value %0d, expected %0d (kind %0d)",
                                              value, exp.value, exp.kind));
                if (last !== exp.last)
                    report_mismatch($sformatf("last %0d, expected %0d (kind %0d)",
                                              last, exp.last, exp.kind));
            end
        endtask
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [VALUE_W-1:0]    cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [VALUE_W-1:0]    s_axis_tdata  = '0;   // [15:0] index
    logic [KIND_W-1:0]     s_axis_tuser  = '0;   // [3:0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]    m_axis_tdata;         // [15:0] out_value
    logic [KIND_W-1:0]     m_axis_tuser;         // [3:0] out_kind
    logic                  m_axis_tlast;

    postfix_scoreboard board = new();
    token_t            token_q [$];
    int                burst_left  = 0;
    int                acted_count = 0;
    int                cycle_count = 0;
    rx_mode_t          rx_mode     = RX_OPEN;
    int                rx_left     = 0;

    infix_to_postfix_converter #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: a random stall pattern, redrawn whenever its hold counter runs out
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:    m_axis_tready <= 1'b1;
            RX_BUSY:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_CHOPPY:  m_axis_tready <= ($urandom_range(0, 1) == 1);
            default:    m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    function automatic void add_token(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] index);
        token_t t;
        t.kind  = kind;
        t.index = index;
        token_q.push_back(t);
    endfunction

    function automatic logic [KIND_W-1:0] random_op();
        case ($urandom_range(0, 3))
            0:       return IN_PLUS;
            1:       return IN_MINUS;
            2:       return IN_STAR;
            default: return IN_SLASH;
        endcase
    endfunction

    // tokens the block ignores while a call is open
    function automatic void add_call_noise();
        case ($urandom_range(0, 4))
            0:       add_token(IN_LPAREN, 16'($urandom));
            1:       add_token(random_op(), 16'($urandom));
            2:       add_token(IN_END, 16'($urandom));
            3:       add_token(IN_USER_FUNC + 4'($urandom_range(0, 2)), 16'($urandom));
            default: add_token(4'($urandom_range(KIND_UNKNOWN_LO, KIND_TOP)), 16'($urandom));
        endcase
    endfunction

    function automatic void gen_call();
        int nargs;
        add_token(IN_USER_FUNC + 4'($urandom_range(0, 2)), 16'($urandom));
        if ($urandom_range(0, 9) < 7) add_token(IN_LPAREN, 16'($urandom));
        // mostly a few arguments, sometimes enough commas to saturate the count
        nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
        for (int i = 0; i < nargs; i++) begin
            if (i > 0) add_token(IN_COMMA, 16'($urandom));
            add_token(IN_OPERAND, 16'($urandom));
            if ($urandom_range(0, 7) == 0) add_call_noise();
        end
        add_token(IN_RPAREN, 16'($urandom));
    endfunction

    function automatic void gen_expr(int lvl);
        int nterms;
        int pick;
        nterms = $urandom_range(1, 4);
        for (int i = 0; i < nterms; i++) begin
            if (i > 0) add_token(random_op(), 16'($urandom));
            pick = $urandom_range(0, 9);
            if (lvl < 4 && pick < 2) begin
                add_token(IN_LPAREN, 16'($urandom));
                gen_expr(lvl + 1);
                add_token(IN_RPAREN, 16'($urandom));
            end else if (pick == 2) begin
                gen_call();
            end else begin
                add_token(IN_OPERAND, 16'($urandom));
            end
        end
    endfunction

    // nest deep enough to fill the stack, sometimes past it
    function automatic void gen_fill();
        int target;
        int pushes;
        target = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
        pushes = 0;
        while (pushes < target) begin
            add_token(IN_LPAREN, 16'($urandom));
            pushes++;
            if (pushes < target && $urandom_range(0, 1)) begin
                add_token(random_op(), 16'($urandom));
                pushes++;
            end
        end
        if ($urandom_range(0, 1)) add_token(random_op(), 16'($urandom));
        for (int i = $urandom_range(0, 3); i > 0; i--) add_token(IN_RPAREN, 16'($urandom));
        add_token(IN_END, 16'($urandom));
    endfunction

    // one random sequence: mostly well-formed expressions, some broken ones and noise
    function automatic void gen_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            gen_expr(0);
            add_token(IN_END, 16'($urandom));
        end else if (pick < 80) begin
            case ($urandom_range(0, 3))
                0: begin
                    gen_expr(0);
                    add_token(IN_RPAREN, 16'($urandom));
                end
                1: begin
                    add_token(IN_LPAREN, 16'($urandom));
                    gen_expr(0);
                end
                2: begin
                    add_token(IN_OPERAND, 16'($urandom));
                    add_token(random_op(), 16'($urandom));
                    add_token(random_op(), 16'($urandom));
                    gen_expr(1);
                end
                default: begin
                    gen_expr(0);
                end
            endcase
            if ($urandom_range(0, 2) != 0) add_token(IN_END, 16'($urandom));
        end else if (pick < 93) begin
            for (int i = $urandom_range(3, 8); i > 0; i--) begin
                add_token(4'($urandom_range(0, KIND_TOP)), 16'($urandom));
            end
        end else if (pick < 97) begin
            gen_fill();
        end else begin
            add_token(IN_COMMA, 16'($urandom));
            add_token(4'($urandom_range(KIND_UNKNOWN_LO, KIND_TOP)), 16'($urandom));
            gen_expr(0);
            add_token(IN_END, 16'($urandom));
        end
    endfunction

    // Sender: bursts of requests with random gaps between them
    task automatic send_token(token_t tok);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= tok.kind;
        s_axis_tdata  <= tok.index;
        do @(posedge aclk); while (!s_axis_tready);
        if (board.note_token(tok)) acted_count++;
        burst_left--;
    endtask

    task automatic send_queued();
        token_t t;
        while (token_q.size() != 0) begin
            t = token_q.pop_front();
            send_token(t);
        end
    endtask

    // hold off new requests until every expected item is out and the block is quiet
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(logic [VALUE_W-1:0] compare_val, logic [VALUE_W-1:0] strlen_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_COMPARE;
        cfg_wdata <= compare_val;
        @(posedge aclk);
        board.set_reg(REG_COMPARE, compare_val);
        cfg_addr  <= REG_STRLEN;
        cfg_wdata <= strlen_val;
        @(posedge aclk);
        board.set_reg(REG_STRLEN, strlen_val);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_regs(16'hFFFF, 16'h0000);

        // operand extremes and every operator, with a parenthesized group
        add_token(IN_OPERAND, 16'h0000);
        add_token(IN_PLUS, 16'h0000);
        add_token(IN_OPERAND, 16'hFFFF);
        add_token(IN_STAR, 16'hFFFF);
        add_token(IN_LPAREN, 16'h0000);
        add_token(IN_OPERAND, 16'h1234);
        add_token(IN_MINUS, 16'h0000);
        add_token(IN_OPERAND, 16'hA5A5);
        add_token(IN_RPAREN, 16'h0000);
        add_token(IN_SLASH, 16'h0000);
        add_token(IN_OPERAND, 16'h5A5A);
        add_token(IN_END, 16'h0000);
        // comma outside a call, unknown kind, rparen on an empty stack
        add_token(IN_COMMA, 16'h0000);
        add_token(KIND_TOP, 16'hFFFF);
        add_token(IN_RPAREN, 16'h0000);
        // compare call with ignored tokens inside, then strlen and a user function
        add_token(IN_COMPARE, 16'h0000);
        add_token(IN_LPAREN, 16'h0000);
        add_token(IN_OPERAND, 16'h0001);
        add_token(IN_COMMA, 16'h0000);
        add_token(IN_PLUS, 16'h0000);
        add_token(IN_END, 16'h0000);
        add_token(IN_STRLEN, 16'h0000);
        add_token(IN_RPAREN, 16'h0000);
        add_token(IN_STRLEN, 16'h0000);
        add_token(IN_RPAREN, 16'h0000);
        add_token(IN_USER_FUNC, 16'hABCD);
        add_token(IN_RPAREN, 16'h0000);
        // leftover lparen flushed by end
        add_token(IN_LPAREN, 16'h0000);
        add_token(IN_OPERAND, 16'h0002);
        add_token(IN_PLUS, 16'h0000);
        add_token(IN_END, 16'h0000);
        send_queued();
        drain_and_settle();

        acted_count = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       write_regs(16'h0000, 16'hFFFF);
                2:       write_regs(16'h8000, 16'h7FFF);
                default: write_regs(16'($urandom), 16'($urandom));
            endcase
            if (phase == 0) gen_fill();
            while (acted_count < (phase + 1) * PHASE_ITEMS) begin
                gen_sequence();
                send_queued();
            end
            drain_and_settle();
        end

        if (board.pending() != 0) begin
            board.report_mismatch($sformatf("%0d items never arrived", board.pending()));
        end
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
